// File: rtl/blr_pkg.sv
// blr_pkg: shared constants and types for the line rasterizer
// used by blr_ctrl, blr_datapath and bresenham_line_raster; depends on nothing

package blr_pkg;

   localparam int COORD_BITS_DEFAULT = 6;
   localparam int COLOR_BITS         = 24;

   // stepping mode: bit 1 set when y falls along rising x, bit 0 set when y is major
   typedef enum logic [1:0] {
      MODE_X_UP   = 2'd0,
      MODE_Y_UP   = 2'd1,
      MODE_X_DOWN = 2'd2,
      MODE_Y_DOWN = 2'd3
   } step_mode_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture request fields
      logic setup;   // order endpoints, pick mode, init error
      logic emit;    // put current pixel in output register and step
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_step;   // current pixel is the final one of the line
   } dp_status_type;

endpackage

// File: rtl/blr_ctrl.sv
// blr_ctrl: sequencer for the line rasterizer (idle, setup, run) and result valid
// depends on blr_pkg for the command and status structs

module blr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output blr_pkg::dp_cmd_type    cmd,
   input  blr_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_RUN   = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.setup = (state_ff == ST_SETUP);
      cmd.emit  = (state_ff == ST_RUN) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // the last pixel goes to the output register, so the next item can enter
            if (out_free && status.last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/blr_datapath.sv
// blr_datapath: endpoint ordering, error stepping and pixel output register
// depends on blr_pkg; driven by blr_ctrl through dp_cmd_type

module blr_datapath #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  blr_pkg::dp_cmd_type            cmd,
   output blr_pkg::dp_status_type         status,
   input  logic [COORD_BITS-1:0]          req_first_x,
   input  logic [COORD_BITS-1:0]          req_first_y,
   input  logic [COORD_BITS-1:0]          req_second_x,
   input  logic [COORD_BITS-1:0]          req_second_y,
   input  logic [blr_pkg::COLOR_BITS-1:0] req_line_color,
   output logic [COORD_BITS-1:0]          rsp_pixel_x,
   output logic [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [blr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);

   localparam int ERR_BITS = COORD_BITS + 3;
   localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   // captured request
   logic [COORD_BITS-1:0]          ax_ff, ay_ff, bx_ff, by_ff;
   logic [blr_pkg::COLOR_BITS-1:0] color_ff;

   // stepping state
   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]  steps_ff, steps_in;
   logic [COORD_BITS-1:0]  major_ff, major_in;
   logic [COORD_BITS-1:0]  minor_ff, minor_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   blr_pkg::step_mode_type mode_ff, mode_in;

   // output register
   logic [COORD_BITS-1:0]          px_ff, py_ff;
   logic [blr_pkg::COLOR_BITS-1:0] pcolor_ff;
   logic                           plast_ff;

   // setup terms
   logic                  swap, y_falls, steep;
   logic [COORD_BITS-1:0] sx, sy, ex, ey, dx, ady;
   logic signed [ERR_BITS-1:0] major_ext;

   // step terms
   logic signed [ERR_BITS-1:0] two_minor, two_major, err_acc;
   logic                       move;

   always_comb begin
      swap    = ax_ff > bx_ff;
      sx      = swap ? bx_ff : ax_ff;
      sy      = swap ? by_ff : ay_ff;
      ex      = swap ? ax_ff : bx_ff;
      ey      = swap ? ay_ff : by_ff;
      dx      = ex - sx;
      y_falls = ey < sy;
      ady     = y_falls ? (sy - ey) : (ey - sy);
      steep   = dx < ady;
      major_in = steep ? ady : dx;
      minor_in = steep ? dx : ady;
      mode_in  = blr_pkg::step_mode_type'({y_falls, steep});
      major_ext = $signed({3'b000, major_in});
   end

   assign two_minor = $signed({2'b00, minor_ff, 1'b0});
   assign two_major = $signed({2'b00, major_ff, 1'b0});

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in   = err_ff;
      steps_in = steps_ff;
      err_acc  = err_ff;
      move     = 1'b0;
      if (cmd.setup) begin
         if (mode_in == blr_pkg::MODE_Y_DOWN) begin
            // steep falling line starts at the lower-y endpoint
            cur_x_in = ex;
            cur_y_in = ey;
         end else begin
            cur_x_in = sx;
            cur_y_in = sy;
         end
         err_in   = y_falls ? major_ext : -major_ext;
         steps_in = major_in;
      end else if (cmd.emit) begin
         steps_in = steps_ff - ONE;
         case (mode_ff)
            blr_pkg::MODE_X_UP: begin
               err_acc  = err_ff + two_minor;
               move     = err_acc >= 0;
               cur_x_in = cur_x_ff + ONE;
               cur_y_in = move ? cur_y_ff + ONE : cur_y_ff;
               err_in   = move ? err_acc - two_major : err_acc;
            end
            blr_pkg::MODE_Y_UP: begin
               err_acc  = err_ff + two_minor;
               move     = err_acc >= 0;
               cur_y_in = cur_y_ff + ONE;
               cur_x_in = move ? cur_x_ff + ONE : cur_x_ff;
               err_in   = move ? err_acc - two_major : err_acc;
            end
            blr_pkg::MODE_X_DOWN: begin
               err_acc  = err_ff - two_minor;
               move     = err_acc <= 0;
               cur_x_in = cur_x_ff + ONE;
               cur_y_in = move ? cur_y_ff - ONE : cur_y_ff;
               err_in   = move ? err_acc + two_major : err_acc;
            end
            default: begin
               err_acc  = err_ff - two_minor;
               move     = err_acc <= 0;
               cur_y_in = cur_y_ff + ONE;
               cur_x_in = move ? cur_x_ff - ONE : cur_x_ff;
               err_in   = move ? err_acc + two_major : err_acc;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff    <= req_first_x;
         ay_ff    <= req_first_y;
         bx_ff    <= req_second_x;
         by_ff    <= req_second_y;
         color_ff <= req_line_color;
      end
      if (cmd.setup) begin
         major_ff <= major_in;
         minor_ff <= minor_in;
         mode_ff  <= mode_in;
      end
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_ff   <= err_in;
      steps_ff <= steps_in;
      if (cmd.emit) begin
         px_ff     <= cur_x_ff;
         py_ff     <= cur_y_ff;
         pcolor_ff <= color_ff;
         plast_ff  <= status.last_step;
      end
   end

   assign status.last_step = (steps_ff == '0);

   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_color = pcolor_ff;
   assign rsp_last_pixel  = plast_ff;

endmodule

// File: rtl/bresenham_line_raster.sv
// bresenham_line_raster: top level of the all-octant line rasterizer
// depends on blr_pkg, blr_ctrl and blr_datapath
//
//   port group  dir  handshake              carries
//   req_*       in   req_valid/req_ready    two endpoints and a line color
//   rsp_*       out  rsp_valid/rsp_ready    one pixel per item, last flag on the end
//
// one request is captured, then set up, then stepped out as major+1 pixels,
// where major is the longer of |dx| and |dy| (up to 2^COORD_BITS pixels).
// the error stepper gives one pixel a cycle into the output register while it is not stalled.
// a stalled rsp_ready holds the stepper; the next request is taken as soon as
// the last pixel of a line is loaded into the output register.
// synchronous reset clears the sequencer and rsp_valid.

module bresenham_line_raster #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [COORD_BITS-1:0]          req_first_x,
   input  logic [COORD_BITS-1:0]          req_first_y,
   input  logic [COORD_BITS-1:0]          req_second_x,
   input  logic [COORD_BITS-1:0]          req_second_y,
   input  logic [blr_pkg::COLOR_BITS-1:0] req_line_color,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [COORD_BITS-1:0]          rsp_pixel_x,
   output logic [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [blr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);

   blr_pkg::dp_cmd_type    cmd;
   blr_pkg::dp_status_type status;

   blr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   blr_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_line_color  (req_line_color),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

// File: sim/line_pixel_checker.sv
// line_pixel_checker: watches the request and pixel channels of the line rasterizer,
// predicts the Bresenham pixel run of every accepted line and compares field by field
// depends on blr_pkg for the stepping mode type and the width constants
`timescale 1ns / 1ps

module line_pixel_checker #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [COORD_BITS-1:0]          req_first_x,
   input  logic [COORD_BITS-1:0]          req_first_y,
   input  logic [COORD_BITS-1:0]          req_second_x,
   input  logic [COORD_BITS-1:0]          req_second_y,
   input  logic [blr_pkg::COLOR_BITS-1:0] req_line_color,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [COORD_BITS-1:0]          rsp_pixel_x,
   input  logic [COORD_BITS-1:0]          rsp_pixel_y,
   input  logic [blr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   input  logic                           rsp_last_pixel,
   output int                             mismatch_count,
   output int                             pixels_pending
);

   typedef struct packed {
      logic [COORD_BITS-1:0]          x;
      logic [COORD_BITS-1:0]          y;
      logic [blr_pkg::COLOR_BITS-1:0] color;
      logic                           last;
   } line_pixel_type;

   line_pixel_type expected_pixels[$];
   int             pixel_index;

   initial begin
      mismatch_count = 0;
      pixels_pending = 0;
      pixel_index    = 0;
   end

   task report_mismatch(input string msg);
      $display("%0t ns: pixel %0d: %s", $time, pixel_index, msg);
      mismatch_count++;
   endtask

   // walks the line exactly as the stepper should and queues every pixel
   task automatic rasterize_line(input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
                                 input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
                                 input logic [blr_pkg::COLOR_BITS-1:0] color);
      int sx, sy, ex, ey, dx, dy;
      int major, minor, err, px, py, n;
      blr_pkg::step_mode_type mode;
      line_pixel_type pix;
      // equal x keeps the first endpoint as the start
      if (ax <= bx) begin
         sx = ax; sy = ay; ex = bx; ey = by;
      end else begin
         sx = bx; sy = by; ex = ax; ey = ay;
      end
      dx = ex - sx;
      dy = ey - sy;
      if (dy >= 0) begin
         if (dx >= dy) begin
            mode = blr_pkg::MODE_X_UP; major = dx; minor = dy;
         end else begin
            mode = blr_pkg::MODE_Y_UP; major = dy; minor = dx;
         end
         px = sx; py = sy;
         err = -major;
      end else begin
         if (dx >= -dy) begin
            mode = blr_pkg::MODE_X_DOWN; major = dx; minor = -dy;
            px = sx; py = sy;
         end else begin
            // steep falling line starts from the lower-y end
            mode = blr_pkg::MODE_Y_DOWN; major = -dy; minor = dx;
            px = ex; py = ey;
         end
         err = major;
      end
      for (n = major; n >= 0; n--) begin
         pix.x     = px[COORD_BITS-1:0];
         pix.y     = py[COORD_BITS-1:0];
         pix.color = color;
         pix.last  = (n == 0);
         expected_pixels.push_back(pix);
         case (mode)
            blr_pkg::MODE_X_UP: begin
               px++;
               err += 2 * minor;
               if (err >= 0) begin
                  py++;
                  err -= 2 * major;
               end
            end
            blr_pkg::MODE_Y_UP: begin
               py++;
               err += 2 * minor;
               if (err >= 0) begin
                  px++;
                  err -= 2 * major;
               end
            end
            blr_pkg::MODE_X_DOWN: begin
               px++;
               err -= 2 * minor;
               if (err <= 0) begin
                  py--;
                  err += 2 * major;
               end
            end
            default: begin
               py++;
               err -= 2 * minor;
               if (err <= 0) begin
                  px--;
                  err += 2 * major;
               end
            end
         endcase
      end
   endtask

   task check_pixel;
      line_pixel_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected item x=%0d y=%0d color=%06h last=%0b",
                                   rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel));
      end else begin
         want = expected_pixels.pop_front();
         if (rsp_pixel_x !== want.x)
            report_mismatch($sformatf("pixel_x got %0d expected %0d", rsp_pixel_x, want.x));
         if (rsp_pixel_y !== want.y)
            report_mismatch($sformatf("pixel_y got %0d expected %0d", rsp_pixel_y, want.y));
         if (rsp_pixel_color !== want.color)
            report_mismatch($sformatf("pixel_color got %06h expected %06h",
                                      rsp_pixel_color, want.color));
         if (rsp_last_pixel !== want.last)
            report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                      rsp_last_pixel, want.last));
      end
      pixel_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         pixels_pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_pixel();
         if (req_valid && req_ready)
            rasterize_line(req_first_x, req_first_y, req_second_x, req_second_y, req_line_color);
         pixels_pending <= expected_pixels.size();
      end
   end

endmodule

// File: sim/bresenham_line_raster_tb.sv
// bresenham_line_raster_tb: drives line requests with bursty timing and a stalling
// pixel receiver, and gives the verdict; depends on blr_pkg, the rasterizer and line_pixel_checker
`timescale 1ns / 1ps

module bresenham_line_raster_tb;

   localparam int CB           = blr_pkg::COORD_BITS_DEFAULT;
   localparam int CMAX         = (1 << CB) - 1;
   localparam int RANDOM_LINES = 128;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   // receiver stall styles
   localparam logic [1:0] READY_ALWAYS = 2'd0;
   localparam logic [1:0] READY_COIN   = 2'd1;
   localparam logic [1:0] READY_RUNS   = 2'd2;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [CB-1:0]                  req_first_x = '0;
   logic [CB-1:0]                  req_first_y = '0;
   logic [CB-1:0]                  req_second_x = '0;
   logic [CB-1:0]                  req_second_y = '0;
   logic [blr_pkg::COLOR_BITS-1:0] req_line_color = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [CB-1:0]                  rsp_pixel_x;
   logic [CB-1:0]                  rsp_pixel_y;
   logic [blr_pkg::COLOR_BITS-1:0] rsp_pixel_color;
   logic                           rsp_last_pixel;

   int         mismatch_count;
   int         pixels_pending;
   int         burst_left = 0;
   int         idle_cycles = 0;
   logic [1:0] stall_style = READY_ALWAYS;
   logic [6:0] style_cycles = '0;
   int         run_left = 0;

   always #5 clock = ~clock;

   bresenham_line_raster #(.COORD_BITS(CB)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_line_color  (req_line_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   line_pixel_checker #(.COORD_BITS(CB)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_line_color  (req_line_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel),
      .mismatch_count  (mismatch_count),
      .pixels_pending  (pixels_pending)
   );

   // receiver: stall style redrawn each time the 7-bit style_cycles counter wraps
   always @(posedge clock) begin
      style_cycles <= style_cycles + 1'b1;
      if (style_cycles == '0)
         stall_style <= 2'($urandom_range(0, 2));
      case (stall_style)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
         default: begin
            if (run_left == 0) begin
               rsp_ready <= ~rsp_ready;
               run_left  <= $urandom_range(1, 6);
            end else begin
               run_left <= run_left - 1;
            end
         end
      endcase
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // offers one line, waits for it to be taken, then maybe opens a gap
   task automatic send_line(input int ax, input int ay, input int bx, input int by,
                            input logic [blr_pkg::COLOR_BITS-1:0] color);
      int gap;
      req_valid      <= 1'b1;
      req_first_x    <= CB'(ax);
      req_first_y    <= CB'(ay);
      req_second_x   <= CB'(bx);
      req_second_y   <= CB'(by);
      req_line_color <= color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
   endfunction

   initial begin
      int ax, ay, bx, by, kind, i;
      logic [blr_pkg::COLOR_BITS-1:0] color;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single points at both corners
      send_line(0, 0, 0, 0, 24'h000000);
      send_line(CMAX, CMAX, CMAX, CMAX, 24'hffffff);
      // vertical lines given bottom-up and top-down
      send_line(5, 2, 5, 20, 24'haaaaaa);
      send_line(9, 30, 9, 4, 24'h555555);
      send_line(CMAX, CMAX, CMAX, 0, 24'h123456);
      // horizontal both ways
      send_line(0, 7, CMAX, 7, 24'hff0000);
      send_line(40, 12, 3, 12, 24'h00ff00);
      // full diagonals in every direction
      send_line(0, 0, CMAX, CMAX, 24'h0000ff);
      send_line(CMAX, CMAX, 0, 0, 24'h808080);
      send_line(0, CMAX, CMAX, 0, 24'h7f7f7f);
      send_line(CMAX, 0, 0, CMAX, 24'h010203);
      // one of each stepping mode, shallow and steep, rising and falling
      send_line(2, 3, 30, 11, 24'hfedcba);
      send_line(4, 1, 13, 40, 24'h0f0f0f);
      send_line(1, 50, 45, 33, 24'hf0f0f0);
      send_line(20, 60, 10, 5, 24'hc3c3c3);
      send_line(3, 60, 7, 2, 24'h3c3c3c);
      // tie rounding, same and opposite direction
      send_line(10, 10, 14, 12, 24'h111111);
      send_line(10, 12, 14, 10, 24'h222222);
      send_line(10, 10, 12, 14, 24'h333333);
      send_line(12, 10, 10, 14, 24'h444444);
      // one step lines
      send_line(CMAX, 0, CMAX - 1, 1, 24'hffffff);
      send_line(0, CMAX, 1, CMAX, 24'h000000);

      for (i = 0; i < RANDOM_LINES; i++) begin
         kind  = $urandom_range(0, 9);
         color = 24'($urandom());
         ax    = $urandom_range(0, CMAX);
         ay    = $urandom_range(0, CMAX);
         if (kind < 5) begin
            bx = $urandom_range(0, CMAX);
            by = $urandom_range(0, CMAX);
         end else if (kind < 8) begin
            // short lines keep the run fast and hit small-delta rounding
            bx = clamp_coord(ax + $urandom_range(0, 8) - 4);
            by = clamp_coord(ay + $urandom_range(0, 8) - 4);
         end else if (kind == 8) begin
            bx = ($urandom_range(0, 1) == 1) ? ax : $urandom_range(0, CMAX);
            by = (bx == ax) ? $urandom_range(0, CMAX) : ay;
         end else begin
            bx = $urandom_range(0, CMAX);
            by = clamp_coord(($urandom_range(0, 1) == 1) ? ay + (bx - ax) : ay - (bx - ax));
         end
         send_line(ax, ay, bx, by, color);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
